// File: rtl/core/keyframe_clock_interpolator_unit_macros.svh
// assertion macros for the keyframe clock interpolator checker
// expects clk and rst_n in the scope of each use
`ifndef KEYFRAME_CLOCK_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_CLOCK_INTERPOLATOR_UNIT_MACROS_SVH

// checked only outside reset
`define KCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define KCI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/kci_pkg.sv
// shared constants for the keyframe clock interpolator
// register indexes, play mode codes, field widths and the play rate reset value; no dependencies
package kci_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 32;
  localparam int POS_W      = 40;
  localparam int FIRST_W    = 16;
  localparam int SECOND_W   = 17;
  localparam int FRAC_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_RATE      = 2'd3;

  localparam logic [1:0] MODE_LOOP   = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_MIRROR = 2'd2;

  localparam logic [15:0] PLAY_RATE_RST = 16'd256;

endpackage

// File: rtl/core/keyframe_clock_interpolator_unit.sv
// keyframe clock interpolator top level: timestamp to keyframe pair and blend weight
// depends on kci_pkg
//
// usage: each in_ channel transaction carries an absolute time (Q16.16 seconds).
// the first transaction after reset only records the time. a later, strictly
// greater time advances the play position (Q24.16 frames, saturating) by
// delta * play_rate * frame_rate, then, if length and frame rate are non-zero, the
// position is wrapped (loop, mirror) or clamped (single). one out_ transaction per
// input: frame_first, frame_second and blend_fraction. the cfg_ port writes play_mode,
// interval_count, frame_rate and play_rate; write only while no transaction is in flight.
// steps: two multiplier passes when time advances, the position update, the wrap
// division when the position wraps, then the output step. the multiplier is a
// bit-serial shift-add unit and the wrap uses a restoring divider (one bit at a
// time). one item is in work at a time, so a new item is taken only once the last
// result is in the output register; in_ready returns together with out_valid,
// even when out_ready is low. a stalled receiver holds the result in
// the output register and the next item waits in its final step for the slot.
// reset (synchronous, active low) clears position, recorded time and registers.
module keyframe_clock_interpolator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kci_pkg::TIME_W-1:0]      in_now_time,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kci_pkg::FIRST_W-1:0]     out_frame_first,
  output logic [kci_pkg::SECOND_W-1:0]    out_frame_second,
  output logic [kci_pkg::FRAC_W-1:0]      out_blend_fraction,
  input  logic                            cfg_we,
  input  logic [kci_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kci_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import kci_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [4:0] MUL_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST = 5'd23;

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [15:0]       fr_r, fr_nxt;
  logic [15:0]       pr_r, pr_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic              seen_r, seen_nxt;
  logic              out_valid_r, out_valid_nxt;

  // datapath
  logic [63:0]         acc_r, acc_nxt;
  logic [63:0]         mcand_r, mcand_nxt;
  logic [15:0]         mlt_r, mlt_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                adv_r, adv_nxt;
  logic [23:0]         div_r, div_nxt;
  logic [16:0]         rem_r, rem_nxt;
  logic [FIRST_W-1:0]  first_r, first_nxt;
  logic [SECOND_W-1:0] second_r, second_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;

  logic [63:0] acc_sum;
  logic [47:0] inc;
  logic [48:0] pos_sum;
  logic [POS_W-1:0] pos_adv, pos_val;
  logic [16:0] divisor;
  logic [17:0] div_t;
  logic [17:0] div_sub;
  logic [16:0] div_rem;
  logic        active;
  logic        wrap;
  logic [23:0] ip;
  logic [16:0] lp_second;
  logic [16:0] len2;
  logic [16:0] ma, ma1;
  logic [16:0] fold_a, fold_a1;
  logic        clamp;
  logic        slot_free;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_frame_first    = first_r;
  assign out_frame_second   = second_r;
  assign out_blend_fraction = frac_r;

  always_comb begin
    // shift-add step, one multiplier bit per cycle
    acc_sum = acc_r + (mlt_r[0] ? mcand_r : 64'd0);

    // saturating position advance
    inc     = acc_r[63:16];
    pos_sum = {9'd0, pos_r} + {1'b0, inc};
    pos_adv = (|pos_sum[48:40]) ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
    pos_val = adv_r ? pos_adv : pos_r;

    // restoring division of the integer part, one quotient bit per cycle
    divisor = (mode_r == MODE_MIRROR) ? {len_r, 1'b0} : {1'b0, len_r};
    div_t   = {rem_r, div_r[23]};
    div_sub = div_t - {1'b0, divisor};
    div_rem = (div_t >= {1'b0, divisor}) ? div_sub[16:0] : div_t[16:0];

    active = (len_r != 16'd0) && (fr_r != 16'd0);
    wrap   = active && ((mode_r == MODE_LOOP) || (mode_r == MODE_MIRROR));

    // result forming from the settled position
    ip        = pos_r[39:16];
    lp_second = {1'b0, ip[15:0]} + 17'd1;
    len2      = {len_r, 1'b0};
    ma        = ip[16:0];
    ma1       = ma + 17'd1;
    fold_a    = (ma <= {1'b0, len_r}) ? ma : (len2 - ma);
    fold_a1   = (ma1 <= {1'b0, len_r}) ? ma1 : (len2 - ma1);
    clamp     = (ip >= {8'd0, len_r});
    slot_free = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    len_nxt       = len_r;
    fr_nxt        = fr_r;
    pr_nxt        = pr_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mlt_nxt       = mlt_r;
    cnt_nxt       = cnt_r;
    adv_nxt       = adv_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    frac_nxt      = frac_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_PLAY_MODE:      mode_nxt = cfg_wdata[1:0];
        REG_INTERVAL_COUNT: len_nxt  = cfg_wdata;
        REG_FRAME_RATE:     fr_nxt   = cfg_wdata;
        REG_PLAY_RATE:      pr_nxt   = cfg_wdata;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          acc_nxt   = 64'd0;
          mcand_nxt = {32'd0, in_now_time - last_r};
          mlt_nxt   = pr_r;
          cnt_nxt   = 5'd0;
          if (!seen_r) begin
            seen_nxt  = 1'b1;
            last_nxt  = in_now_time;
            adv_nxt   = 1'b0;
            state_nxt = S_ACC;
          end else if (in_now_time > last_r) begin
            last_nxt  = in_now_time;
            adv_nxt   = 1'b1;
            state_nxt = S_MUL1;
          end else begin
            adv_nxt   = 1'b0;
            state_nxt = S_ACC;
          end
        end
      end
      S_MUL1, S_MUL2: begin
        acc_nxt   = acc_sum;
        mcand_nxt = {mcand_r[62:0], 1'b0};
        mlt_nxt   = {1'b0, mlt_r[15:1]};
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r == MUL_LAST) begin
          cnt_nxt = 5'd0;
          if (state_r == S_MUL1) begin
            // second pass multiplies the partial product by the frame rate
            acc_nxt   = 64'd0;
            mcand_nxt = acc_sum;
            mlt_nxt   = fr_r;
            state_nxt = S_MUL2;
          end else begin
            state_nxt = S_ACC;
          end
        end
      end
      S_ACC: begin
        pos_nxt = pos_val;
        div_nxt = pos_val[39:16];
        rem_nxt = 17'd0;
        cnt_nxt = 5'd0;
        state_nxt = wrap ? S_MOD : S_DONE;
      end
      S_MOD: begin
        rem_nxt = div_rem;
        div_nxt = {div_r[22:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          pos_nxt   = {7'd0, div_rem, pos_r[15:0]};
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          first_nxt     = '0;
          second_nxt    = '0;
          frac_nxt      = '0;
          if (active) begin
            unique case (mode_r)
              MODE_LOOP: begin
                first_nxt  = ip[15:0];
                second_nxt = lp_second;
                frac_nxt   = pos_r[15:0];
              end
              MODE_SINGLE: begin
                if (clamp) begin
                  pos_nxt    = {8'd0, len_r, 16'd0};
                  first_nxt  = len_r;
                  second_nxt = {1'b0, len_r};
                end else begin
                  first_nxt  = ip[15:0];
                  second_nxt = lp_second;
                  frac_nxt   = pos_r[15:0];
                end
              end
              MODE_MIRROR: begin
                first_nxt  = fold_a[15:0];
                second_nxt = fold_a1;
                frac_nxt   = pos_r[15:0];
              end
              default: begin
                first_nxt = '0;
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_LOOP;
      len_r       <= 16'd0;
      fr_r        <= 16'd0;
      pr_r        <= PLAY_RATE_RST;
      pos_r       <= '0;
      last_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= 5'd0;
      adv_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      fr_r        <= fr_nxt;
      pr_r        <= pr_nxt;
      pos_r       <= pos_nxt;
      last_r      <= last_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      adv_r       <= adv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mlt_r    <= mlt_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
    frac_r   <= frac_nxt;
  end

endmodule

// File: rtl/core/kci_checker.sv
// port-level checker for the keyframe clock interpolator, bound to the top level
// depends on kci_pkg and keyframe_clock_interpolator_unit_macros.svh
`include "keyframe_clock_interpolator_unit_macros.svh"

module kci_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [kci_pkg::FIRST_W-1:0]   out_frame_first,
  input logic [kci_pkg::SECOND_W-1:0]  out_frame_second,
  input logic [kci_pkg::FRAC_W-1:0]    out_blend_fraction
);
  import kci_pkg::*;

  // one item in work at a time
  `KCI_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted while busy")
  // a stalled result stays put
  `KCI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_frame_first), "result dropped under stall")
  `KCI_ASSERT(a_frac_hold, out_valid && !out_ready |=> $stable(out_blend_fraction), "fraction changed under stall")
  // equal keyframes only come from a clamp, a disabled track or the unused mode, all with zero weight
  `KCI_ASSERT(a_same_frame_zero, out_valid && !out_frame_second[SECOND_W-1] && out_frame_second[FIRST_W-1:0] == out_frame_first |-> out_blend_fraction == '0, "weight on equal frames")
  `KCI_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result after reset")

endmodule

bind keyframe_clock_interpolator_unit kci_checker u_kci_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for keyframe_clock_interpolator_unit: timestamps in, keyframe pairs out
// keeps its own play position model to predict every result; depends on kci_pkg and the rtl

module testbench;
  import kci_pkg::*;

  localparam logic [1:0]       MODE_UNUSED = 2'd3;
  localparam logic [POS_W-1:0] POS_FULL    = {POS_W{1'b1}};
  localparam int SEGMENTS    = 15;
  localparam int SEG_ITEMS   = 50;
  localparam int HOLD_SEG    = 3;
  localparam int PAUSE_SEG   = 7;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 64;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [FIRST_W-1:0]  first;
    logic [SECOND_W-1:0] second;
    logic [FRAC_W-1:0]   frac;
  } frame_pick_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [TIME_W-1:0]     in_now_time = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [FIRST_W-1:0]    out_frame_first;
  logic [SECOND_W-1:0]   out_frame_second;
  logic [FRAC_W-1:0]     out_blend_fraction;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  // predictor copy of registers and play state
  logic [1:0]        mdl_mode   = MODE_LOOP;
  logic [15:0]       mdl_len    = '0;
  logic [15:0]       mdl_fps    = '0;
  logic [15:0]       mdl_speed  = PLAY_RATE_RST;
  logic [POS_W-1:0]  play_pos   = '0;
  logic [TIME_W-1:0] last_stamp = '0;
  logic              stamp_seen = 1'b0;

  logic [TIME_W-1:0] stamp_queue[$];
  frame_pick_t       expected_picks[$];
  frame_pick_t       oldest_pick;
  int                stamps_issued = 0;
  int                stamps_taken  = 0;
  int                mismatches    = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                holds_asked   = 0;
  int                holds_done    = 0;
  int                hold_left     = 0;

  keyframe_clock_interpolator_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_now_time        (in_now_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_first    (out_frame_first),
    .out_frame_second   (out_frame_second),
    .out_blend_fraction (out_blend_fraction),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [17:0] mirror_fold(logic [17:0] idx, logic [15:0] len);
    return (idx <= 18'(len)) ? idx : ((18'(len) << 1) - idx);
  endfunction

  // advances the play position for one timestamp and returns the keyframe pair
  function automatic frame_pick_t advance_and_pick(logic [TIME_W-1:0] now);
    frame_pick_t       pick;
    logic [TIME_W-1:0] delta;
    logic [63:0]       inc;
    logic [41:0]       span;
    logic [17:0]       idx;
    pick = '0;
    if (!stamp_seen) begin
      stamp_seen = 1'b1;
      last_stamp = now;
    end else if (now > last_stamp) begin
      delta      = now - last_stamp;
      inc        = (64'(delta) * 64'(mdl_speed) * 64'(mdl_fps)) >> 16;
      last_stamp = now;
      if (inc >= 64'(POS_FULL) - 64'(play_pos)) play_pos = POS_FULL;
      else play_pos = play_pos + inc[POS_W-1:0];
    end
    if (mdl_len != 16'd0 && mdl_fps != 16'd0) begin
      span = 42'(mdl_len) << 16;
      case (mdl_mode)
        MODE_LOOP: begin
          play_pos    = POS_W'(42'(play_pos) % span);
          pick.first  = play_pos[31:16];
          pick.second = 17'(play_pos[31:16]) + 17'd1;
          pick.frac   = play_pos[15:0];
        end
        MODE_SINGLE: begin
          if (42'(play_pos) >= span) begin
            // clamped on the last keyframe
            play_pos    = span[POS_W-1:0];
            pick.first  = mdl_len;
            pick.second = 17'(mdl_len);
          end else begin
            pick.first  = play_pos[31:16];
            pick.second = 17'(play_pos[31:16]) + 17'd1;
            pick.frac   = play_pos[15:0];
          end
        end
        MODE_MIRROR: begin
          play_pos    = POS_W'(42'(play_pos) % (span << 1));
          idx         = play_pos[33:16];
          pick.first  = 16'(mirror_fold(idx, mdl_len));
          pick.second = 17'(mirror_fold(idx + 18'd1, mdl_len));
          pick.frac   = play_pos[15:0];
        end
        default: ;
      endcase
    end
    return pick;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_PLAY_MODE:      mdl_mode  = data[1:0];
      REG_INTERVAL_COUNT: mdl_len   = data;
      REG_FRAME_RATE:     mdl_fps   = data;
      default:            mdl_speed = data;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] mode_word, len, fps, speed);
    write_reg(REG_PLAY_MODE, mode_word);
    write_reg(REG_INTERVAL_COUNT, len);
    write_reg(REG_FRAME_RATE, fps);
    write_reg(REG_PLAY_RATE, speed);
    @(posedge clk);
  endtask

  task automatic drain_all();
    while (stamp_queue.size() != 0 || in_valid || expected_picks.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // timestamp driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || stamps_taken == stamps_issued)) begin
      if (stamp_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid    <= 1'b1;
        in_now_time <= stamp_queue.pop_front();
        stamps_issued++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: predicts on each input transaction, checks each result transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      stamps_taken++;
      expected_picks.push_back(advance_and_pick(in_now_time));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result transaction: frame_first %0d frame_second %0d blend_fraction %0d",
               out_frame_first, out_frame_second, out_blend_fraction);
        mismatches++;
      end else begin
        oldest_pick = expected_picks.pop_front();
        if (out_frame_first !== oldest_pick.first) begin
          $error("frame_first: expected %0d actual %0d", oldest_pick.first, out_frame_first);
          mismatches++;
        end
        if (out_frame_second !== oldest_pick.second) begin
          $error("frame_second: expected %0d actual %0d", oldest_pick.second, out_frame_second);
          mismatches++;
        end
        if (out_blend_fraction !== oldest_pick.frac) begin
          $error("blend_fraction: expected %0h actual %0h", oldest_pick.frac,
                 out_blend_fraction);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles_run;
    for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++) @(posedge clk);
    $error("timeout after %0d cycles", CYCLE_LIMIT);
    $display("** keyframe_clock_interpolator_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int                seg;
    int                k;
    int                pick_kind;
    int                mode_pick;
    logic [TIME_W-1:0] cursor;
    logic [TIME_W-1:0] step;
    logic [15:0]       mode_word;
    logic [15:0]       len_v;
    logic [15:0]       fps_v;
    logic [15:0]       speed_v;

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    send_idle_pct = 31;
    recv_idle_pct = 72;

    // loop mode, junk in the upper mode bits; first stamp only records, then equal,
    // earlier, forward, wrapping forward and zero
    apply_setting(16'hFFFC, 16'd16, 16'd7680, 16'd256);
    stamp_queue.push_back(32'h0000_1000);
    stamp_queue.push_back(32'h0000_1000);
    stamp_queue.push_back(32'h0000_0800);
    stamp_queue.push_back(32'h0000_8000);
    stamp_queue.push_back(32'h0002_0000);
    stamp_queue.push_back(32'h0000_0000);
    drain_all();

    // single play runs into the clamp
    apply_setting({14'd0, MODE_SINGLE}, 16'd4, 16'd7680, 16'd256);
    stamp_queue.push_back(32'h0002_0100);
    stamp_queue.push_back(32'h0003_0000);
    stamp_queue.push_back(32'h0003_0000);
    drain_all();

    // mirror at half speed folds back past the end
    apply_setting({14'd0, MODE_MIRROR}, 16'd3, 16'd6144, 16'h0080);
    stamp_queue.push_back(32'h0003_1000);
    stamp_queue.push_back(32'h0003_8000);
    stamp_queue.push_back(32'h0004_0000);
    stamp_queue.push_back(32'h0005_0000);
    drain_all();

    // unused mode with full rates drives the position into saturation
    apply_setting(16'hFFFF, 16'd5, 16'hFFFF, 16'hFFFF);
    stamp_queue.push_back(32'h0005_0000);
    stamp_queue.push_back(32'h0105_0000);
    stamp_queue.push_back(32'h0205_0000);
    drain_all();

    // longest loop shows the saturated position wrapped
    apply_setting({14'd0, MODE_LOOP}, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    stamp_queue.push_back(32'h0205_0000);
    stamp_queue.push_back(32'h0205_0001);
    drain_all();

    // zero length, then zero frame rate, then zero speed
    apply_setting({14'd0, MODE_LOOP}, 16'd0, 16'd256, 16'd256);
    stamp_queue.push_back(32'h0206_0000);
    stamp_queue.push_back(32'h0207_0000);
    drain_all();
    apply_setting({14'd0, MODE_LOOP}, 16'd7, 16'd0, 16'd256);
    stamp_queue.push_back(32'h0208_0000);
    drain_all();
    apply_setting({14'd0, MODE_MIRROR}, 16'd7, 16'd256, 16'd0);
    stamp_queue.push_back(32'h0209_0000);
    stamp_queue.push_back(32'h020A_0000);
    drain_all();

    // random part advances a cursor through the upper half of the time range; some stamps go back below it
    cursor = 32'h8000_0000 | 32'($urandom_range(0, 32'h00FF_FFFF));
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 5) begin
        send_idle_pct = 31;
        recv_idle_pct = 72;
      end else if (seg < 10) begin
        send_idle_pct = 72;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      mode_word = 16'($urandom);
      mode_pick = $urandom_range(0, 9);
      mode_word[1:0] = (mode_pick < 3) ? MODE_LOOP :
                       (mode_pick < 6) ? MODE_SINGLE :
                       (mode_pick < 9) ? MODE_MIRROR : MODE_UNUSED;
      case ($urandom_range(0, 19))
        0:       len_v = 16'd0;
        1:       len_v = 16'hFFFF;
        2, 3, 4: len_v = 16'($urandom);
        default: len_v = 16'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 19))
        0:       fps_v = 16'd0;
        1:       fps_v = 16'hFFFF;
        2, 3:    fps_v = 16'($urandom);
        default: fps_v = 16'($urandom_range(12, 120)) << 8;
      endcase
      case ($urandom_range(0, 19))
        0:       speed_v = 16'd0;
        1:       speed_v = 16'hFFFF;
        2, 3:    speed_v = 16'($urandom);
        default: speed_v = 16'($urandom_range(64, 1024));
      endcase
      apply_setting(mode_word, len_v, fps_v, speed_v);

      for (k = 0; k < SEG_ITEMS; k++) begin
        if (seg == PAUSE_SEG && k == SEG_ITEMS / 2) drain_all();
        pick_kind = $urandom_range(0, 99);
        if (pick_kind < 70) step = $urandom_range(1, 32'h3000);
        else if (pick_kind < 80) step = $urandom_range(32'h3000, 32'h0010_0000);
        else if (pick_kind < 82) step = 32'h0100_0000;
        else step = '0;
        // never run past the end of the time range
        if (step > ~cursor) step = '0;
        if (pick_kind >= 90) begin
          stamp_queue.push_back($urandom_range(0, cursor));
        end else begin
          cursor = cursor + step;
          stamp_queue.push_back(cursor);
        end
      end
      if (seg == HOLD_SEG) holds_asked++;
      if (seg == SEGMENTS - 1) stamp_queue.push_back(32'hFFFF_FFFF);
      drain_all();
    end

    if (mismatches == 0 && expected_picks.size() == 0)
      $display("** keyframe_clock_interpolator_unit: PASSED **");
    else
      $display("** keyframe_clock_interpolator_unit: FAILED **");
    $finish;
  end

endmodule
